// ----- rtl/log_peak_level_meter_defines.svh -----
// Assertion macros shared by the checker files of the peak level meter.
// Depends on nothing; LPM_ASSERT expects clk and rst_n in scope, LPM_ASSERT_ANY only clk.
`ifndef LOG_PEAK_LEVEL_METER_DEFINES_SVH
`define LOG_PEAK_LEVEL_METER_DEFINES_SVH

// Property checked out of reset only
`define LPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included
`define LPM_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/lpm_pkg.sv -----
// Shared types, constants and the log ROM builder for the peak level meter.
// No dependencies; imported by every lpm_* module.
package lpm_pkg;

  localparam int LOG_TABLE_BITS = 10;
  localparam int LOG_TABLE_SIZE = 1 << LOG_TABLE_BITS;
  localparam int LOG_FRAC       = 24;

  localparam int SAMPLE_W   = 16;
  localparam int PEAK_W     = 15;
  localparam int COUNT_W    = 16;
  localparam int LEVEL_W    = 16;
  localparam int COEFF_W    = 16;
  localparam int ACC_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH = 2'd0,
    CFG_ATTACK        = 2'd1,
    CFG_RELEASE       = 2'd2
  } cfg_index_t;

  localparam logic [COUNT_W-1:0] WINDOW_LENGTH_RST = 16'd512;
  localparam logic [COEFF_W-1:0] ATTACK_RST        = 16'd6554;
  localparam logic [COEFF_W-1:0] RELEASE_RST       = 16'd7;

  typedef logic [LOG_TABLE_BITS-1:0] rom_addr_t;
  typedef logic [LEVEL_W-1:0]        level_t;

  // Window tracker result for the word moving into the ROM stage
  typedef struct packed {
    rom_addr_t rom_addr;
    logic      window_end;
  } win_info_t;

  // Smoothing weights
  typedef struct packed {
    logic [COEFF_W-1:0] attack;
    logic [COEFF_W-1:0] release_coeff;
  } coeff_t;

  typedef logic [LEVEL_W-1:0] log_rom_t [LOG_TABLE_SIZE];

  // log2 with LOG_FRAC fraction bits: integer part from the leading one,
  // fraction bits by repeated squaring of the Q1.30 mantissa (truncated).
  function automatic logic [63:0] fixed_log2(input logic [31:0] x);
    logic [31:0] xv;
    int unsigned n;
    logic [63:0] m;
    logic [63:0] res;
    xv = (x == 32'd0) ? 32'd1 : x;
    n  = 0;
    while (n < 31 && (xv >> (n + 1)) != 32'd0) n++;
    m   = {32'd0, xv} << (30 - n);
    res = 64'(n) << LOG_FRAC;
    for (int k = LOG_FRAC - 1; k >= 0; k--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m      = m >> 1;
        res[k] = 1'b1;
      end
    end
    return res;
  endfunction

  localparam logic [63:0] LOG2_D  = fixed_log2(32'(LOG_TABLE_SIZE - 1));
  localparam logic [63:0] LOG2_40 = fixed_log2(32'd40);

  // Entry i: log10(39p+1)/log10(40) in Q0.16, p = i / (size - 1), saturated
  function automatic log_rom_t build_log_rom();
    log_rom_t rom;
    logic [63:0] diff;
    logic [63:0] v;
    for (int i = 0; i < LOG_TABLE_SIZE; i++) begin
      diff   = fixed_log2(32'(39 * i + LOG_TABLE_SIZE - 1)) - LOG2_D;
      v      = (diff * 64'd65536 + LOG2_40 / 2) / LOG2_40;
      rom[i] = (v > 64'd65535) ? 16'hFFFF : v[LEVEL_W-1:0];
    end
    return rom;
  endfunction

endpackage

// ----- rtl/log_peak_level_meter.sv -----
// Log peak level meter, top level: handshake pipeline and config registers.
// Depends on lpm_pkg, lpm_peak_window, lpm_log_rom, lpm_smoother.
//
// Usage:
//   Input channel (in_valid/in_ready/in_sample) takes one signed Q1.15 audio
//   word per cycle while in_ready is high. Output channel (out_valid/out_ready)
//   gives one word per input: out_level (Q0.16 smoothed log peak) and out_window_end.
//   Config: cfg_we with cfg_index/cfg_wdata writes window_length, attack or
//   release weight; write only while the pipeline is empty.
//   Pipeline: input register, log ROM read register, output register.
//   Throughput: one word/cycle while out_ready stays high.
//   Each stage holds its word when the next stage is full, so a stalled
//   receiver fills the three stages before in_ready drops; bubbles are
//   squeezed out. The peak/count loop and the smoothing loop (one 16x32
//   multiply) each close with no pipeline register inside the loop.
//   Reset (rst_n low, synchronous): pipeline empties, peak, count, target
//   and level go to zero, registers return to 512 / 6554 / 7.
module log_peak_level_meter import lpm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [LEVEL_W-1:0]         out_level,
  output logic                       out_window_end,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

  logic                       a_valid_r;
  logic signed [SAMPLE_W-1:0] a_sample_r;
  logic                       b_valid_r;
  logic                       b_end_r;
  logic                       out_valid_r;
  level_t                     out_level_r;
  logic                       out_end_r;

  logic [COUNT_W-1:0] window_length_r;
  coeff_t             coeff_r;

  logic      c_ready, b_ready, a_ready;
  logic      a_move, b_move, in_fire;
  win_info_t win_info;
  level_t    rom_data;
  level_t    level_nxt;

  // Per-stage ready: a stage can take a word if empty or its word moves on
  assign c_ready = !out_valid_r || out_ready;
  assign b_ready = !b_valid_r || c_ready;
  assign a_ready = !a_valid_r || b_ready;
  assign b_move  = b_valid_r && c_ready;
  assign a_move  = a_valid_r && b_ready;
  assign in_fire = in_valid && a_ready;

  assign in_ready       = a_ready;
  assign out_valid      = out_valid_r;
  assign out_level      = out_level_r;
  assign out_window_end = out_end_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r       <= WINDOW_LENGTH_RST;
      coeff_r.attack        <= ATTACK_RST;
      coeff_r.release_coeff <= RELEASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_LENGTH: window_length_r       <= cfg_wdata;
        CFG_ATTACK:        coeff_r.attack        <= cfg_wdata;
        CFG_RELEASE:       coeff_r.release_coeff <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        a_valid_r <= 1'b1;
      end else if (a_move) begin
        a_valid_r <= 1'b0;
      end
      if (a_move) begin
        b_valid_r <= 1'b1;
      end else if (b_move) begin
        b_valid_r <= 1'b0;
      end
      if (b_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_sample_r <= in_sample;
    end
    if (a_move) begin
      b_end_r <= win_info.window_end;
    end
    if (b_move) begin
      out_level_r <= level_nxt;
      out_end_r   <= b_end_r;
    end
  end

  lpm_peak_window u_window (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (a_move),
    .sample        (a_sample_r),
    .window_length (window_length_r),
    .info          (win_info)
  );

  lpm_log_rom u_rom (
    .clk     (clk),
    .rd_en   (a_move),
    .rd_addr (win_info.rom_addr),
    .rd_data (rom_data)
  );

  lpm_smoother u_smooth (
    .clk        (clk),
    .rst_n      (rst_n),
    .update     (b_move),
    .window_end (b_end_r),
    .rom_data   (rom_data),
    .coeff      (coeff_r),
    .level_nxt  (level_nxt)
  );

endmodule

// ----- rtl/lpm_log_rom.sv -----
// Log-scale lookup ROM with registered read.
// Depends on lpm_pkg (table builder, address and data types).
module lpm_log_rom import lpm_pkg::*; (
  input  logic      clk,
  input  logic      rd_en,
  input  rom_addr_t rd_addr,
  output level_t    rd_data
);

  localparam log_rom_t LOG_ROM = build_log_rom();

  level_t rd_data_r;

  // Synchronous read, held while the stage is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= LOG_ROM[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/lpm_peak_window.sv -----
// Magnitude, running peak and window counter; yields ROM address and window end.
// Depends on lpm_pkg.
module lpm_peak_window import lpm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [COUNT_W-1:0]         window_length,
  output win_info_t                  info
);

  logic [PEAK_W-1:0]   peak_r, peak_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [SAMPLE_W-1:0] neg;
  logic [PEAK_W-1:0]   mag;
  logic [PEAK_W-1:0]   peak_incl;
  logic [COUNT_W:0]    count_inc;
  logic                win_end;

  // Magnitude clamped to 32767 (most negative sample included)
  always_comb begin
    neg = SAMPLE_W'(-sample);
    if (sample[SAMPLE_W-1]) begin
      mag = neg[SAMPLE_W-1] ? {PEAK_W{1'b1}} : neg[PEAK_W-1:0];
    end else begin
      mag = sample[PEAK_W-1:0];
    end
  end

  // Peak including this word, count and window end check
  always_comb begin
    peak_incl = (mag > peak_r) ? mag : peak_r;
    count_inc = {1'b0, count_r} + (COUNT_W+1)'(1);
    win_end   = (count_inc >= {1'b0, window_length});
    peak_nxt  = win_end ? '0 : peak_incl;
    count_nxt = win_end ? '0 : count_inc[COUNT_W-1:0];
  end

  assign info.rom_addr   = peak_incl[PEAK_W-1 -: LOG_TABLE_BITS];
  assign info.window_end = win_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r  <= '0;
      count_r <= '0;
    end else if (advance) begin
      peak_r  <= peak_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- rtl/lpm_smoother.sv -----
// Target level register and attack/release smoothing of the Q0.32 level.
// Depends on lpm_pkg.
module lpm_smoother import lpm_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   update,
  input  logic   window_end,
  input  level_t rom_data,
  input  coeff_t coeff,
  output level_t level_nxt
);

  level_t             target_r, target_nxt;
  logic [ACC_W-1:0]   smooth_r, smooth_nxt;
  logic [ACC_W-1:0]   target_wide;
  logic [ACC_W-1:0]   diff;
  logic [COEFF_W-1:0] weight;
  logic [ACC_W+COEFF_W-1:0] prod;
  logic [ACC_W-1:0]   step;
  logic               rising;

  // One step toward the (possibly new) target; never passes it
  always_comb begin
    target_nxt  = window_end ? rom_data : target_r;
    target_wide = {target_nxt, {(ACC_W-LEVEL_W){1'b0}}};
    rising      = (target_wide > smooth_r);
    diff        = rising ? (target_wide - smooth_r) : (smooth_r - target_wide);
    weight      = rising ? coeff.attack : coeff.release_coeff;
    prod        = weight * diff;
    step        = prod[ACC_W+COEFF_W-1:COEFF_W];
    smooth_nxt  = rising ? (smooth_r + step) : (smooth_r - step);
  end

  assign level_nxt = smooth_nxt[ACC_W-1 -: LEVEL_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      smooth_r <= '0;
    end else if (update) begin
      target_r <= target_nxt;
      smooth_r <= smooth_nxt;
    end
  end

endmodule

// ----- rtl/lpm_checker.sv -----
// Port-level checks for the log peak level meter, bound to the top level.
// Depends on lpm_pkg and log_peak_level_meter_defines.svh.
`include "log_peak_level_meter_defines.svh"

module lpm_checker import lpm_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [LEVEL_W-1:0] out_level,
  input logic               out_window_end
);

  // Reset empties the output register
  `LPM_ASSERT_ANY(a_rst_empty, !rst_n |=> !out_valid, "out_valid set after reset")

  // Empty output stage means the whole pipe can take a word
  `LPM_ASSERT(a_empty_ready, !out_valid |-> in_ready, "in_ready low with empty output")

  // A stalled result holds
  `LPM_ASSERT(a_out_hold,
    out_valid && !out_ready |=> out_valid && $stable(out_level) && $stable(out_window_end),
    "stalled result changed")

  // The input only stalls behind a stalled result
  `LPM_ASSERT(a_in_stall, !in_ready |-> out_valid && !out_ready, "input stalled without cause")

  // A waiting input word stays offered until taken
  `LPM_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid, "input word withdrawn")

endmodule

bind log_peak_level_meter lpm_checker u_lpm_checker (.*);

// ----- tb/sv/log_peak_level_meter_test.sv -----
// Self-checking testbench for log_peak_level_meter: directed plan, then random phases.
// Depends on lpm_pkg (widths, register indexes, reset values) and the RTL top level.
`timescale 1ns / 1ps

module log_peak_level_meter_test;
  import lpm_pkg::*;

  localparam int RANDOM_WORDS   = 1700;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;
  localparam int DRAIN_CYCLES   = 8;

  // Index past the last register; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef enum logic {ROW_WRITE, ROW_WORD} row_kind_t;
  typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_t;
  typedef enum int {SHAPE_NOISE, SHAPE_BURST, SHAPE_EDGE, SHAPE_QUIET} sample_shape_t;

  typedef struct packed {
    level_t level;
    logic   window_end;
  } meter_word_t;

  // Directed row: register write (idx/data) or sample word (data), optionally pinned
  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [15:0]           data;
    logic                  pinned;
    level_t                pin_level;
    logic                  pin_end;
  } plan_row_t;

  localparam int PLAN_ROWS = 32;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // fresh from reset: target and level are zero until the first window ends
    '{ROW_WORD,  '0,                16'h0000, 1'b1, 16'd0, 1'b0},
    '{ROW_WORD,  '0,                16'h7FFF, 1'b1, 16'd0, 1'b0},
    '{ROW_WORD,  '0,                16'h8000, 1'b1, 16'd0, 1'b0},
    '{ROW_WORD,  '0,                16'hFFFF, 1'b1, 16'd0, 1'b0},
    '{ROW_WORD,  '0,                16'h0001, 1'b1, 16'd0, 1'b0},
    // window shortened below the running count: next word closes it
    '{ROW_WRITE, CFG_WINDOW_LENGTH, 16'd3,    1'b0, 16'd0, 1'b0},
    '{ROW_WORD,  '0,                16'h4000, 1'b0, 16'd0, 1'b0},
    // zero length acts as one
    '{ROW_WRITE, CFG_WINDOW_LENGTH, 16'd0,    1'b0, 16'd0, 1'b0},
    '{ROW_WORD,  '0,                16'h8000, 1'b0, 16'd0, 1'b0},
    '{ROW_WORD,  '0,                16'h7FFF, 1'b0, 16'd0, 1'b0},
    '{ROW_WORD,  '0,                16'h0000, 1'b0, 16'd0, 1'b0},
    // full attack, no release
    '{ROW_WRITE, CFG_ATTACK,        16'hFFFF, 1'b0, 16'd0, 1'b0},
    '{ROW_WRITE, CFG_RELEASE,       16'h0000, 1'b0, 16'd0, 1'b0},
    '{ROW_WORD,  '0,                16'h2000, 1'b0, 16'd0, 1'b0},
    '{ROW_WORD,  '0,                16'h0000, 1'b0, 16'd0, 1'b0},
    // no attack, full release
    '{ROW_WRITE, CFG_ATTACK,        16'h0000, 1'b0, 16'd0, 1'b0},
    '{ROW_WRITE, CFG_RELEASE,       16'hFFFF, 1'b0, 16'd0, 1'b0},
    '{ROW_WORD,  '0,                16'h7FFF, 1'b0, 16'd0, 1'b0},
    '{ROW_WORD,  '0,                16'h0000, 1'b0, 16'd0, 1'b0},
    // out-of-range index, then back to longer windows
    '{ROW_WRITE, CFG_SPARE_IDX,     16'h0005, 1'b0, 16'd0, 1'b0},
    '{ROW_WRITE, CFG_WINDOW_LENGTH, 16'd1,    1'b0, 16'd0, 1'b0},
    '{ROW_WORD,  '0,                16'h5555, 1'b0, 16'd0, 1'b0},
    '{ROW_WORD,  '0,                16'hAAAA, 1'b0, 16'd0, 1'b0},
    '{ROW_WRITE, CFG_WINDOW_LENGTH, 16'hFFFF, 1'b0, 16'd0, 1'b0},
    '{ROW_WRITE, CFG_ATTACK,        ATTACK_RST,  1'b0, 16'd0, 1'b0},
    '{ROW_WRITE, CFG_RELEASE,       RELEASE_RST, 1'b0, 16'd0, 1'b0},
    '{ROW_WORD,  '0,                16'h7FFE, 1'b0, 16'd0, 1'b0},
    '{ROW_WORD,  '0,                16'h8001, 1'b0, 16'd0, 1'b0},
    '{ROW_WORD,  '0,                16'h0100, 1'b0, 16'd0, 1'b0},
    '{ROW_WRITE, CFG_WINDOW_LENGTH, 16'd2,    1'b0, 16'd0, 1'b0},
    '{ROW_WORD,  '0,                16'hFFFE, 1'b0, 16'd0, 1'b0},
    '{ROW_WORD,  '0,                16'h0000, 1'b0, 16'd0, 1'b0}
  };

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  level_t                     out_level;
  logic                       out_window_end;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata = '0;

  // Pinned expectation travels with the word, driven alongside it
  logic   pin_on = 1'b0;
  level_t pin_level = '0;
  logic   pin_end = 1'b0;

  log_peak_level_meter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_level      (out_level),
    .out_window_end (out_window_end),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Meter state mirrored by the predictor
  level_t      log_level_rom [LOG_TABLE_SIZE];
  logic [14:0] peak_hold   = '0;
  logic [15:0] win_count   = '0;
  level_t      target_lvl  = '0;
  logic [31:0] smooth_acc  = '0;
  logic [15:0] win_len_reg = WINDOW_LENGTH_RST;
  logic [15:0] att_reg     = ATTACK_RST;
  logic [15:0] rel_reg     = RELEASE_RST;

  meter_word_t level_expect_q [$];
  int words_sent    = 0;
  int words_checked = 0;
  int mismatches    = 0;
  int windows_seen  = 0;
  int reg_writes    = 0;
  int phases        = 0;
  int idle_cycles   = 0;
  int stall_left    = 0;
  idle_mode_t send_mode  = IDLE_LIGHT;
  idle_mode_t ready_mode = IDLE_LIGHT;

  // log2 in Q.24: leading one gives the integer part, squaring the mantissa the fraction
  function automatic logic [63:0] log2_q24(input logic [31:0] x);
    logic [63:0] mant;
    logic [63:0] acc;
    int          lead;
    lead = 0;
    for (int b = 0; b < 32; b++)
      if (x[b]) lead = b;
    mant = 64'(x) << (30 - lead);
    acc  = 64'(lead) << 24;
    for (int k = 23; k >= 0; k--) begin
      mant = (mant * mant) >> 30;
      if (mant[31]) begin
        mant   = mant >> 1;
        acc[k] = 1'b1;
      end
    end
    return acc;
  endfunction

  // One sample word through peak, window and smoothing
  function automatic meter_word_t advance_meter(input logic [15:0] raw);
    logic [16:0] mag;
    logic [16:0] cnt_next;
    logic [63:0] t;
    logic [63:0] s;
    logic        wend;
    wend = 1'b0;
    mag  = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    if (mag > 17'd32767) mag = 17'd32767;
    if (mag[14:0] > peak_hold) peak_hold = mag[14:0];
    cnt_next = {1'b0, win_count} + 17'd1;
    if (cnt_next >= {1'b0, win_len_reg}) begin
      target_lvl = log_level_rom[peak_hold[14 -: LOG_TABLE_BITS]];
      peak_hold  = '0;
      win_count  = '0;
      wend       = 1'b1;
      windows_seen++;
    end else begin
      win_count = cnt_next[15:0];
    end
    t = 64'(target_lvl) << 16;
    s = 64'(smooth_acc);
    if (t > s) s = s + ((64'(att_reg) * (t - s)) >> 16);
    else       s = s - ((64'(rel_reg) * (s - t)) >> 16);
    smooth_acc = s[31:0];
    return '{level: smooth_acc[31:16], window_end: wend};
  endfunction

  // Gap length: mostly short, a few long
  function automatic int idle_len(input idle_mode_t mode);
    int r;
    r = $urandom_range(0, 19);
    case (mode)
      IDLE_NONE:  return 0;
      IDLE_LIGHT: return (r < 14) ? 0 : $urandom_range(1, 3);
      default: begin
        if (r < 14) return 0;
        if (r < 19) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
      end
    endcase
  endfunction

  function automatic logic [15:0] next_sample(input sample_shape_t shape, input int amp);
    int mag;
    int pick;
    case (shape)
      SHAPE_NOISE: return 16'($urandom_range(0, 65535));
      SHAPE_EDGE: begin
        pick = $urandom_range(0, 5);
        case (pick)
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h0000;
          3:       return 16'h0001;
          4:       return 16'hFFFF;
          default: return 16'h8001;
        endcase
      end
      SHAPE_QUIET: mag = $urandom_range(0, 64);
      default:     mag = $urandom_range(0, amp);
    endcase
    if ($urandom_range(0, 1) == 1) return 16'(-mag);
    return 16'((mag > 32767) ? 32767 : mag);
  endfunction

  // Receiver: ready with random stalls
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= idle_len(ready_mode);
    end
  end

  // Predict on input accept, check on output accept, watchdog on silence
  always @(posedge clk) begin : monitor
    meter_word_t predicted;
    meter_word_t want;
    logic        traffic;
    traffic = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        traffic   = 1'b1;
        predicted = advance_meter(in_sample);
        if (pin_on) level_expect_q.push_back('{level: pin_level, window_end: pin_end});
        else        level_expect_q.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        traffic = 1'b1;
        if (level_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected word: level %0d window_end %0b", out_level, out_window_end);
        end else begin
          want = level_expect_q.pop_front();
          if (out_level !== want.level || out_window_end !== want.window_end) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("word %0d: level exp %0d got %0d, window_end exp %0b got %0b",
                       words_checked, want.level, out_level, want.window_end,
                       out_window_end);
          end
          words_checked++;
        end
      end
      if (traffic) idle_cycles = 0;
      else         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("log_peak_level_meter regression: fail");
        $finish;
      end
    end
  end

  task automatic push_word(input logic [15:0] s, input logic pin, input level_t pl,
                           input logic pe, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    pin_on    <= pin;
    pin_level <= pl;
    pin_end   <= pe;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Hold the sender until every outstanding word has come back
  task automatic drain();
    in_valid <= 1'b0;
    wait (words_checked == words_sent);
    @(posedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WINDOW_LENGTH: win_len_reg = value;
      CFG_ATTACK:        att_reg     = value;
      CFG_RELEASE:       rel_reg     = value;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [63:0]   log2_d;
    logic [63:0]   log2_40;
    logic [63:0]   diff;
    logic [63:0]   v;
    int            target_words;
    int            phase_words;
    int            amp;
    sample_shape_t shape;
    logic [15:0]   win;
    logic [15:0]   coeff;

    // Log ROM: entry i maps p = i / (size-1) to log10(39p+1)/log10(40)
    log2_d  = log2_q24(32'(LOG_TABLE_SIZE - 1));
    log2_40 = log2_q24(32'd40);
    for (int i = 0; i < LOG_TABLE_SIZE; i++) begin
      diff = log2_q24(32'(39 * i + LOG_TABLE_SIZE - 1)) - log2_d;
      v    = (diff * 64'd65536 + log2_40 / 2) / log2_40;
      log_level_rom[i] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed plan
    foreach (PLAN[r]) begin
      if (PLAN[r].kind == ROW_WRITE) begin
        drain();
        set_register(PLAN[r].idx, PLAN[r].data);
      end else begin
        push_word(PLAN[r].data, PLAN[r].pinned, PLAN[r].pin_level, PLAN[r].pin_end,
                  idle_len(send_mode));
      end
    end

    // Random phases: new settings while idle, counter carried across
    target_words = words_sent + RANDOM_WORDS;
    while (words_sent < target_words) begin
      drain();
      phases++;
      case ($urandom_range(0, 9))
        0:       win = 16'd0;
        1:       win = 16'd1;
        2:       win = 16'hFFFF;
        3, 4, 5, 6: win = 16'($urandom_range(2, 40));
        7, 8:    win = 16'($urandom_range(41, 600));
        default: win = 16'($urandom_range(0, 65535));
      endcase
      set_register(CFG_WINDOW_LENGTH, win);
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0:       coeff = 16'h0000;
          1:       coeff = 16'hFFFF;
          2:       coeff = ATTACK_RST;
          default: coeff = 16'($urandom_range(0, 65535));
        endcase
        set_register(CFG_ATTACK, coeff);
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0:       coeff = 16'h0000;
          1:       coeff = 16'hFFFF;
          2:       coeff = RELEASE_RST;
          3:       coeff = 16'($urandom_range(1, 64));
          default: coeff = 16'($urandom_range(0, 65535));
        endcase
        set_register(CFG_RELEASE, coeff);
      end
      if ($urandom_range(0, 7) == 0)
        set_register(CFG_SPARE_IDX, 16'($urandom_range(0, 65535)));

      send_mode  = idle_mode_t'($urandom_range(0, 2));
      ready_mode = idle_mode_t'($urandom_range(0, 2));
      shape       = sample_shape_t'($urandom_range(0, 3));
      if ($urandom_range(0, 1) == 1) shape = SHAPE_BURST;
      amp         = $urandom_range(0, 32768);
      phase_words = $urandom_range(20, 120);

      repeat (phase_words) begin
        // bursts swing between loud and silent so both weights get exercised
        if (shape == SHAPE_BURST && $urandom_range(0, 15) == 0)
          amp = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(0, 32768);
        if ($urandom_range(0, 149) == 0) drain();
        push_word(next_sample(shape, amp), 1'b0, '0, 1'b0, idle_len(send_mode));
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d sample words, %0d window ends, %0d register writes, %0d phases",
             words_sent, windows_seen, reg_writes, phases);
    $display("%0d words checked, %0d mismatches", words_checked, mismatches);
    if (mismatches == 0 && level_expect_q.size() == 0) begin
      $display("log_peak_level_meter regression: pass");
    end else begin
      $display("log_peak_level_meter regression: fail");
    end
    $finish;
  end

endmodule
